[hdl/tcb_pkg.sv]
// Package for the text cell buffer: grid geometry, function and character codes,
// the sequencer state type and the structs that pass between the modules.
// No dependencies.
package tcb_pkg;

  localparam int GRID_COLS  = 16;
  localparam int GRID_ROWS  = 4;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int CHAR_W     = 7;

  localparam logic [1:0] FUNC_TEXT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;

  localparam logic [7:0]        CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0]        CHAR_SPACE   = 8'h20;
  localparam logic [7:0]        CHAR_TILDE   = 8'h7E;
  localparam logic [CHAR_W-1:0] CELL_SPACE   = CHAR_W'(CHAR_SPACE);
  localparam logic [CHAR_W-1:0] CELL_ZERO    = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEXT,
    S_RD,
    S_CMP,
    S_FLUSH
  } tcb_state_t;

  // Requests from the sequencer to the cell store.
  typedef struct packed {
    logic              pend_clr;
    logic              pend_we;
    logic [CELL_W-1:0] pend_waddr;
    logic [CHAR_W-1:0] pend_wdata;
    logic              rd_en;
    logic [CELL_W-1:0] raddr;
    logic              shown_we;
    logic [CELL_W-1:0] shown_waddr;
    logic [CHAR_W-1:0] shown_wdata;
  } tcb_mem_req_t;

  // One changed cell handed to the output register.
  typedef struct packed {
    logic              push;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } tcb_push_t;

endpackage

[hdl/text_cell_buffer_diff_update.sv]
// Text cell buffer with dirty update. A text byte is handled in S_TEXT, a clear only drops
// the per-cell valid bits, and an update is the accept, then one read and one compare per
// cell (on the shared comparator) and a flush, plus any stall.
// A changed cell is held until the next difference is found; the last is pushed in the flush.
// Synchronous active-low reset clears the sequencer and the valid bits; no sweep.
module text_cell_buffer_diff_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [7:0]                  in_text_byte,
  input  logic [7:0]                  in_start_col,
  input  logic [7:0]                  in_start_row,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcb_pkg::COL_W-1:0]   out_cell_col,
  output logic [tcb_pkg::ROW_W-1:0]   out_cell_row,
  output logic [tcb_pkg::CHAR_W-1:0]  out_char_code,
  output logic                        out_last_change
);
  import tcb_pkg::*;

  tcb_mem_req_t      mem_req;
  tcb_push_t         push;
  logic [CHAR_W-1:0] pend_q, shown_q;
  logic              slot_free;

  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [CHAR_W-1:0] out_ch_r;
  logic              out_last_r;

  // The sequencer holds back each changed cell until it knows whether another
  // follows, so the last one of a scan can be marked. The output register
  // here decouples the scan from the consumer: a word may be loaded in the
  // same cycle that the previous one is taken.
  assign slot_free = !out_valid_r || out_ready;

  tcb_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_text_byte (in_text_byte),
    .in_start_col (in_start_col),
    .in_start_row (in_start_row),
    .in_last_byte (in_last_byte),
    .slot_free    (slot_free),
    .pend_q       (pend_q),
    .shown_q      (shown_q),
    .mem_req      (mem_req),
    .push_o       (push)
  );

  // Both grids live here; each cell read is registered, so a compare happens
  // the cycle after its read.
  tcb_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .pend_q  (pend_q),
    .shown_q (shown_q)
  );

  assign out_valid_nxt = push.push || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      out_col_r  <= push.col;
      out_row_r  <= push.row;
      out_ch_r   <= push.ch;
      out_last_r <= push.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_col    = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_char_code   = out_ch_r;
  assign out_last_change = out_last_r;

endmodule

[hdl/tcb_cell_store.sv]
// Pending and shown cell grids with per-cell valid bits.
// Depends on tcb_pkg. An invalid pending cell reads as a space, an invalid shown cell as zero.
module tcb_cell_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcb_pkg::tcb_mem_req_t        req,
  output logic [tcb_pkg::CHAR_W-1:0]   pend_q,
  output logic [tcb_pkg::CHAR_W-1:0]   shown_q
);
  import tcb_pkg::*;

  logic [CHAR_W-1:0] pend_mem  [CELL_COUNT];
  logic [CHAR_W-1:0] shown_mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] pend_vld_r, pend_vld_nxt;
  logic [CELL_COUNT-1:0] shown_vld_r, shown_vld_nxt;
  logic [CHAR_W-1:0] pend_rd_r, shown_rd_r;
  logic              pend_rv_r, shown_rv_r;

  always_ff @(posedge clk) begin
    if (req.pend_we) begin
      pend_mem[req.pend_waddr] <= req.pend_wdata;
    end
    if (req.shown_we) begin
      shown_mem[req.shown_waddr] <= req.shown_wdata;
    end
    if (req.rd_en) begin
      pend_rd_r  <= pend_mem[req.raddr];
      shown_rd_r <= shown_mem[req.raddr];
      pend_rv_r  <= pend_vld_r[req.raddr];
      shown_rv_r <= shown_vld_r[req.raddr];
    end
  end

  // Clearing the pending grid only drops the valid bits.
  always_comb begin
    pend_vld_nxt  = pend_vld_r;
    shown_vld_nxt = shown_vld_r;
    if (req.pend_clr) begin
      pend_vld_nxt = '0;
    end else if (req.pend_we) begin
      pend_vld_nxt[req.pend_waddr] = 1'b1;
    end
    if (req.shown_we) begin
      shown_vld_nxt[req.shown_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= '0;
      shown_vld_r <= '0;
    end else begin
      pend_vld_r  <= pend_vld_nxt;
      shown_vld_r <= shown_vld_nxt;
    end
  end

  assign pend_q  = pend_rv_r  ? pend_rd_r  : CELL_SPACE;
  assign shown_q = shown_rv_r ? shown_rd_r : CELL_ZERO;

endmodule

[hdl/tcb_seq.sv]
// Sequencer: cursor handling for text bytes and the cell-by-cell update scan
// around one shared cell comparator. Depends on tcb_pkg.
module tcb_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [7:0]                  in_text_byte,
  input  logic [7:0]                  in_start_col,
  input  logic [7:0]                  in_start_row,
  input  logic                        in_last_byte,
  input  logic                        slot_free,
  input  logic [tcb_pkg::CHAR_W-1:0]  pend_q,
  input  logic [tcb_pkg::CHAR_W-1:0]  shown_q,
  output tcb_pkg::tcb_mem_req_t       mem_req,
  output tcb_pkg::tcb_push_t          push_o
);
  import tcb_pkg::*;

  tcb_state_t state_r, state_nxt;

  logic [7:0] byte_r, scol_r, srow_r;
  logic       last_r;
  logic [7:0] cursor_col_r, cursor_col_nxt;
  logic [7:0] cursor_row_r, cursor_row_nxt;
  logic [7:0] anchor_col_r, anchor_col_nxt;
  logic       in_run_r, in_run_nxt;

  logic [COL_W-1:0]  scan_col_r;
  logic [ROW_W-1:0]  scan_row_r;
  logic [CELL_W-1:0] scan_addr;
  logic              scan_last;

  logic              held_v_r;
  logic [COL_W-1:0]  held_col_r;
  logic [ROW_W-1:0]  held_row_r;
  logic [CHAR_W-1:0] held_ch_r;

  logic       accept;
  logic [7:0] eff_col, eff_row, eff_anchor;
  logic       printable, in_grid;
  logic [CELL_W-1:0] text_addr;
  logic       diff, stall, step;

  assign accept = in_valid && in_ready;

  // Text byte datapath: the run start is taken when no run is open.
  always_comb begin
    eff_col    = in_run_r ? cursor_col_r : scol_r;
    eff_row    = in_run_r ? cursor_row_r : srow_r;
    eff_anchor = in_run_r ? anchor_col_r : scol_r;
    printable  = (byte_r >= CHAR_SPACE) && (byte_r <= CHAR_TILDE);
    in_grid    = (eff_col < 8'(GRID_COLS)) && (eff_row < 8'(GRID_ROWS));
    text_addr  = CELL_W'(eff_row[ROW_W-1:0]) * CELL_W'(GRID_COLS)
               + CELL_W'(eff_col[COL_W-1:0]);
    cursor_col_nxt = eff_col;
    cursor_row_nxt = eff_row;
    if (byte_r == CHAR_NEWLINE) begin
      cursor_row_nxt = eff_row + 8'd1;
      cursor_col_nxt = eff_anchor;
    end else if (printable) begin
      cursor_col_nxt = eff_col + 8'd1;
    end
    anchor_col_nxt = eff_anchor;
    in_run_nxt     = !last_r;
  end

  assign scan_addr = CELL_W'(scan_row_r) * CELL_W'(GRID_COLS) + CELL_W'(scan_col_r);
  assign scan_last = (scan_col_r == COL_W'(GRID_COLS - 1))
                  && (scan_row_r == ROW_W'(GRID_ROWS - 1));
  assign diff  = (pend_q != shown_q);
  assign stall = diff && held_v_r && !slot_free;
  assign step  = (state_r == S_CMP) && !stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_TEXT) begin
          state_nxt = S_TEXT;
        end else if (accept && in_func == FUNC_UPDATE) begin
          state_nxt = S_RD;
        end
      end
      S_TEXT: state_nxt = S_IDLE;
      S_RD:   state_nxt = S_CMP;
      S_CMP: begin
        if (step) begin
          state_nxt = scan_last ? S_FLUSH : S_RD;
        end
      end
      S_FLUSH: begin
        if (!held_v_r || slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready            = (state_r == S_IDLE);
    mem_req             = '0;
    mem_req.pend_clr    = accept && (in_func == FUNC_CLEAR);
    mem_req.pend_we     = (state_r == S_TEXT) && printable && in_grid;
    mem_req.pend_waddr  = text_addr;
    mem_req.pend_wdata  = byte_r[CHAR_W-1:0];
    mem_req.rd_en       = (state_r == S_RD);
    mem_req.raddr       = scan_addr;
    mem_req.shown_we    = step;
    mem_req.shown_waddr = scan_addr;
    mem_req.shown_wdata = pend_q;
    push_o.col  = held_col_r;
    push_o.row  = held_row_r;
    push_o.ch   = held_ch_r;
    push_o.last = (state_r == S_FLUSH);
    push_o.push = held_v_r && slot_free
               && (((state_r == S_CMP) && diff) || (state_r == S_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      anchor_col_r <= '0;
      in_run_r     <= 1'b0;
      held_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_TEXT) begin
        cursor_col_r <= cursor_col_nxt;
        cursor_row_r <= cursor_row_nxt;
        anchor_col_r <= anchor_col_nxt;
        in_run_r     <= in_run_nxt;
      end
      if (accept && in_func == FUNC_UPDATE) begin
        held_v_r <= 1'b0;
      end else if (step && diff) begin
        held_v_r <= 1'b1;
      end else if (push_o.push && state_r == S_FLUSH) begin
        held_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
      scol_r <= in_start_col;
      srow_r <= in_start_row;
      last_r <= in_last_byte;
    end
    if (accept && in_func == FUNC_UPDATE) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else if (step) begin
      if (scan_col_r == COL_W'(GRID_COLS - 1)) begin
        scan_col_r <= '0;
        scan_row_r <= scan_row_r + ROW_W'(1);
      end else begin
        scan_col_r <= scan_col_r + COL_W'(1);
      end
    end
    if (step && diff) begin
      held_col_r <= scan_col_r;
      held_row_r <= scan_row_r;
      held_ch_r  <= pend_q;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push |-> slot_free)
    else $error("changed cell pushed into a full output register");

  a_shown_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.shown_we |-> (state_r == S_CMP) && !in_ready)
    else $error("shown grid written outside the update scan");

  a_held_after_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (step && diff) |=> held_v_r)
    else $error("changed cell lost by the holding register");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && !held_v_r) |=> state_r == S_IDLE)
    else $error("update scan did not finish after an empty flush");

endmodule
